// ===== src/euler_to_rotation_matrix_defines.svh =====
// Assertion macros for the rotation matrix block.
// No dependencies; included by files that hold assertions.
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`ifndef SYNTH
`define E2R_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define E2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define E2R_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define E2R_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/e2r_pkg.sv =====
// Shared types, constants and arithmetic helpers for the rotation matrix block.
// No dependencies.
package e2r_pkg;
  localparam int FractionBitsDef = 14;
  localparam int InnerBits = 30;
  localparam logic [31:0] PiQ29 = 32'd1686629713;
  localparam logic [32:0] InnerOne = 33'h1_0000_0000 >> 2;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } e2r_in_t;

  typedef struct packed {
    logic signed [15:0] row0_col0;
    logic signed [15:0] row0_col1;
    logic signed [15:0] row0_col2;
    logic signed [15:0] row1_col0;
    logic signed [15:0] row1_col1;
    logic signed [15:0] row1_col2;
    logic signed [15:0] row2_col0;
    logic signed [15:0] row2_col1;
    logic signed [15:0] row2_col2;
  } e2r_out_t;

  // unsigned Q2.30 product, rounded half up (operands below 2^31)
  function automatic logic [32:0] umul_q(input logic [32:0] a, input logic [32:0] b);
    logic [65:0] p;
    begin
      p = a * b + 66'(1 << (InnerBits - 1));
      umul_q = p[62:30];
    end
  endfunction

  // signed Q2.30 product, halves away from zero
  function automatic logic signed [33:0] smul_q(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic [32:0] ua;
    logic [32:0] ub;
    logic [32:0] m;
    begin
      ua = a[33] ? 33'(-a) : a[32:0];
      ub = b[33] ? 33'(-b) : b[32:0];
      m = umul_q(ua, ub);
      smul_q = (a[33] ^ b[33]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  endfunction

  // reciprocal for an exact floor(v / d) over 30-bit v: (v * m) >> s
  function automatic logic [31:0] recip_m(input int d);
    begin
      recip_m = 32'(((64'd1 << (InnerBits + $clog2(d))) + 64'(d) - 64'd1) / 64'(d));
    end
  endfunction

  function automatic int recip_s(input int d);
    begin
      recip_s = InnerBits + $clog2(d);
    end
  endfunction

  function automatic logic [29:0] div_rcp(input logic [29:0] v, input logic [31:0] m,
                                          input int s);
    logic [61:0] p;
    begin
      p = 62'(v) * 62'(m);
      div_rcp = 30'(p >> s);
    end
  endfunction
endpackage

// ===== src/e2r_sincos.sv =====
// Pipelined sine and cosine of a binary angle, Q2.30, polynomial by Horner stages.
// Depends on e2r_pkg. Each Horner step is a divide stage then a multiply stage.
module e2r_sincos import e2r_pkg::*; (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [33:0] sin_q,
  output logic signed [33:0] cos_q
);
  localparam int Steps = 11;
  localparam logic [31:0] Rcp72 = recip_m(72);
  localparam logic [31:0] Rcp42 = recip_m(42);
  localparam logic [31:0] Rcp20 = recip_m(20);
  localparam logic [31:0] Rcp6  = recip_m(6);
  localparam logic [31:0] Rcp90 = recip_m(90);
  localparam logic [31:0] Rcp56 = recip_m(56);
  localparam logic [31:0] Rcp30 = recip_m(30);
  localparam logic [31:0] Rcp12 = recip_m(12);
  localparam int Shf72 = recip_s(72);
  localparam int Shf42 = recip_s(42);
  localparam int Shf20 = recip_s(20);
  localparam int Shf6  = recip_s(6);
  localparam int Shf90 = recip_s(90);
  localparam int Shf56 = recip_s(56);
  localparam int Shf30 = recip_s(30);
  localparam int Shf12 = recip_s(12);

  logic [1:0]  q_r   [0:Steps-1];
  logic        neg_r [0:Steps-1];
  logic [32:0] x_r   [0:8];
  logic [32:0] x2_r  [1:8];
  logic [32:0] ts_r  [2:Steps-1];
  logic [32:0] tc_r  [2:Steps-1];
  logic [1:0]  q0;
  logic [15:0] rw;
  logic [16:0] mag;
  logic [48:0] xw;

  always_comb begin
    q0  = 2'((17'(angle) + 17'd8192) >> 14);
    rw  = angle - {q0, 14'd0};
    mag = rw[15] ? 17'h10000 - 17'(rw) : 17'(rw);
    xw  = 49'(mag) * 49'(PiQ29) + 49'd8192;
  end

  // stage 0: angle reduction; stage 1: x^2; even stages divide, odd stages multiply.
  // x2 and every Horner product stay below 2^30, so the dividends fit 30 bits.
  always_ff @(posedge clk) begin
    q_r[0] <= q0; neg_r[0] <= rw[15]; x_r[0] <= xw[46:14];
    x2_r[1] <= umul_q(x_r[0], x_r[0]);
    for (int i = 1; i < Steps; i++) begin
      q_r[i] <= q_r[i-1]; neg_r[i] <= neg_r[i-1];
    end
    for (int i = 1; i < 9; i++) x_r[i] <= x_r[i-1];
    for (int i = 2; i < 9; i++) x2_r[i] <= x2_r[i-1];
    ts_r[2] <= InnerOne - 33'(div_rcp(x2_r[1][29:0], Rcp72, Shf72));
    tc_r[2] <= InnerOne - 33'(div_rcp(x2_r[1][29:0], Rcp90, Shf90));
    ts_r[3] <= umul_q(x2_r[2], ts_r[2]);
    tc_r[3] <= umul_q(x2_r[2], tc_r[2]);
    ts_r[4] <= InnerOne - 33'(div_rcp(ts_r[3][29:0], Rcp42, Shf42));
    tc_r[4] <= InnerOne - 33'(div_rcp(tc_r[3][29:0], Rcp56, Shf56));
    ts_r[5] <= umul_q(x2_r[4], ts_r[4]);
    tc_r[5] <= umul_q(x2_r[4], tc_r[4]);
    ts_r[6] <= InnerOne - 33'(div_rcp(ts_r[5][29:0], Rcp20, Shf20));
    tc_r[6] <= InnerOne - 33'(div_rcp(tc_r[5][29:0], Rcp30, Shf30));
    ts_r[7] <= umul_q(x2_r[6], ts_r[6]);
    tc_r[7] <= umul_q(x2_r[6], tc_r[6]);
    ts_r[8] <= InnerOne - 33'(div_rcp(ts_r[7][29:0], Rcp6, Shf6));
    tc_r[8] <= InnerOne - 33'(div_rcp(tc_r[7][29:0], Rcp12, Shf12));
    ts_r[9] <= umul_q(x_r[8], ts_r[8]);
    tc_r[9] <= umul_q(x2_r[8], tc_r[8]);
    ts_r[10] <= ts_r[9];
    tc_r[10] <= InnerOne - (tc_r[9] >> 1);
  end

  logic signed [33:0] s;
  logic signed [33:0] c;
  always_comb begin
    s = neg_r[Steps-1] ? -$signed({1'b0, ts_r[Steps-1]}) : $signed({1'b0, ts_r[Steps-1]});
    c = $signed({1'b0, tc_r[Steps-1]});
    unique case (q_r[Steps-1])
      2'd0: begin sin_q = s;  cos_q = c;  end
      2'd1: begin sin_q = c;  cos_q = -s; end
      2'd2: begin sin_q = -s; cos_q = -c; end
      default: begin sin_q = -c; cos_q = s; end
    endcase
  end
endmodule

// ===== src/e2r_matrix.sv =====
// Product matrix stages: partial products, entries, rounding and saturation.
// Depends on e2r_pkg.
module e2r_matrix import e2r_pkg::*; #(
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic               clk,
  input  logic signed [33:0] sr, cr, sp, cp, sy, cy,
  output e2r_out_t           mat
);
  localparam int D = InnerBits - FRACTION_BITS;
  logic signed [33:0] spsr_r, spcr_r, sr_r, cr_r, sp_r, cp_r, sy_r, cy_r;
  logic signed [35:0] e_r [9];

  function automatic logic [15:0] to_field(input logic signed [35:0] v);
    logic [35:0] m;
    logic [35:0] lim;
    logic [35:0] r;
    begin
      lim = 36'(1) << FRACTION_BITS;
      m = v[35] ? 36'(-v) : 36'(v);
      m = (D > 0) ? ((m + (36'(1) << (D > 0 ? D - 1 : 0))) >> D) : m;
      if (m > lim) m = lim;
      r = v[35] ? -m : m;
      to_field = r[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    spsr_r <= smul_q(sp, sr); spcr_r <= smul_q(sp, cr);
    sr_r <= sr; cr_r <= cr; sp_r <= sp; cp_r <= cp; sy_r <= sy; cy_r <= cy;
    e_r[0] <= 36'(smul_q(cy_r, cr_r)) - 36'(smul_q(sy_r, spsr_r));
    e_r[1] <= -(36'(smul_q(sy_r, spcr_r)) + 36'(smul_q(cy_r, sr_r)));
    e_r[2] <= -36'(smul_q(sy_r, cp_r));
    e_r[3] <= 36'(smul_q(cp_r, sr_r));
    e_r[4] <= 36'(smul_q(cp_r, cr_r));
    e_r[5] <= -36'(sp_r);
    e_r[6] <= 36'(smul_q(cy_r, spsr_r)) + 36'(smul_q(sy_r, cr_r));
    e_r[7] <= 36'(smul_q(cy_r, spcr_r)) - 36'(smul_q(sy_r, sr_r));
    e_r[8] <= 36'(smul_q(cy_r, cp_r));
    mat <= '{to_field(e_r[0]), to_field(e_r[1]), to_field(e_r[2]),
             to_field(e_r[3]), to_field(e_r[4]), to_field(e_r[5]),
             to_field(e_r[6]), to_field(e_r[7]), to_field(e_r[8])};
  end
endmodule

// ===== src/euler_to_rotation_matrix.sv =====
// Throughput: one word per cycle.
// busy is always low; the pipeline never stalls since the receiver cannot.
// out_valid trails start through the eleven-stage sine/cosine pipe and the three matrix stages.
// Reset (rst_n, synchronous, active low) clears only the valid pipe.
// Depends on e2r_pkg, e2r_sincos, e2r_matrix.
`include "euler_to_rotation_matrix_defines.svh"
module euler_to_rotation_matrix import e2r_pkg::*; #(
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  e2r_in_t  in_data,
  output logic     out_valid,
  output e2r_out_t out_data
);
  localparam int Lat = 14;
  logic [Lat-1:0] vld_r;
  logic [Lat-1:0] vld_nxt;
  logic signed [33:0] sr, cr, sp, cp, sy, cy;

  assign busy = 1'b0;
  assign vld_nxt = {vld_r[Lat-2:0], start};
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end
  assign out_valid = vld_r[Lat-1];

  e2r_sincos u_roll  (.clk, .angle(in_data.roll_angle),  .sin_q(sr), .cos_q(cr));
  e2r_sincos u_pitch (.clk, .angle(in_data.pitch_angle), .sin_q(sp), .cos_q(cp));
  e2r_sincos u_yaw   (.clk, .angle(in_data.yaw_angle),   .sin_q(sy), .cos_q(cy));

  e2r_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_mat (
    .clk, .sr, .cr, .sp, .cp, .sy, .cy, .mat(out_data)
  );

  `E2R_ASSERT_NEXT(a_vld_follow, clk, rst_n, start, vld_r[0])
  `E2R_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)
  `E2R_ASSERT_NEXT(a_out_trail, clk, rst_n, vld_r[Lat-2], out_valid)
endmodule
